FILE: hw/rtl/b64le_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the alphabet lookup for the base64 line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

	// Byte, group and line counter widths.
	localparam int BYTE_W  = 8;
	localparam int GROUP_W = 6;
	localparam int LINE_W  = 8;

	// Line length after reset.
	localparam logic [LINE_W-1:0] LINE_LEN_RESET = 8'd76;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// ASCII anchors of the alphabet ranges.
	localparam logic [7:0] ASCII_UPPER_A = 8'd65;
	localparam logic [7:0] ASCII_LOWER_A = 8'd97;
	localparam logic [7:0] ASCII_ZERO    = 8'd48;
	localparam logic [7:0] ASCII_PLUS    = 8'd43;
	localparam logic [7:0] ASCII_SLASH   = 8'd47;

	// Number of message bits held over from the previous byte.
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_TWO  = 2'd1,
		PEND_FOUR = 2'd2
	} pend_cnt_t;

	// One queue entry: the one or two character groups caused by one byte.
	typedef struct packed {
		logic [GROUP_W-1:0] grp0;
		logic [GROUP_W-1:0] grp1;
		logic               two_chars;
		logic               msg_last;
	} q_entry_t;

	// Map a 6-bit group to its ASCII character.
	function automatic logic [7:0] b64_char(input logic [GROUP_W-1:0] grp);
		logic [7:0] g8;
		g8 = {2'b00, grp};
		case (grp) inside
			[6'd0:6'd25]:  return g8 + ASCII_UPPER_A;
			[6'd26:6'd51]: return g8 + (ASCII_LOWER_A - 8'd26);
			[6'd52:6'd61]: return g8 + ASCII_ZERO - 8'd52;
			6'd62:         return ASCII_PLUS;
			default:       return ASCII_SLASH;
		endcase
	endfunction

endpackage

FILE: hw/rtl/b64le_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_front
// Accepts bytes, joins them with the held-over bits and splits the result into
// one or two 6-bit groups, which it writes into the queue as one entry.
// ----------------------------------------------------------------------------
module b64le_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output b64le_pkg::q_entry_t   q_entry
);
	import b64le_pkg::*;

	pend_cnt_t   pend_cnt_q;
	logic [3:0]  pend_bits_q;
	pend_cnt_t   pend_cnt_d;
	logic [3:0]  pend_bits_d;

	// The queue slot decides whether a transaction can be taken.
	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Build the entry from the held-over bits and the new byte.
	always_comb begin
		q_entry.msg_last = last_byte;
		case (pend_cnt_q)
			PEND_TWO: begin
				q_entry.grp0      = {pend_bits_q[1:0], data_byte[7:4]};
				q_entry.grp1      = {data_byte[3:0], 2'b00};
				q_entry.two_chars = last_byte;
			end
			PEND_FOUR: begin
				q_entry.grp0      = {pend_bits_q, data_byte[7:6]};
				q_entry.grp1      = data_byte[5:0];
				q_entry.two_chars = 1'b1;
			end
			default: begin
				q_entry.grp0      = data_byte[7:2];
				q_entry.grp1      = {data_byte[1:0], 4'b0000};
				q_entry.two_chars = last_byte;
			end
		endcase
	end

	// Work out what is held over for the next byte.
	always_comb begin
		pend_cnt_d  = PEND_NONE;
		pend_bits_d = 4'b0000;
		if (!last_byte) begin
			case (pend_cnt_q)
				PEND_TWO: begin
					pend_cnt_d  = PEND_FOUR;
					pend_bits_d = data_byte[3:0];
				end
				PEND_FOUR: begin
					pend_cnt_d  = PEND_NONE;
					pend_bits_d = 4'b0000;
				end
				default: begin
					pend_cnt_d  = PEND_TWO;
					pend_bits_d = {2'b00, data_byte[1:0]};
				end
			endcase
		end
	end

	// Held-over state advances on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= PEND_NONE;
			pend_bits_q <= 4'b0000;
		end else if (q_push) begin
			pend_cnt_q  <= pend_cnt_d;
			pend_bits_q <= pend_bits_d;
		end
	end

endmodule

FILE: hw/rtl/b64le_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_queue
// Short first-in first-out queue of byte entries between front and back.
// ----------------------------------------------------------------------------
module b64le_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64le_pkg::q_entry_t   push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output b64le_pkg::q_entry_t   head_entry
);
	import b64le_pkg::*;

	q_entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	// Pointer advance with wrap at the queue depth.
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
		if (ptr == QPTR_W'(QDEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: hw/rtl/b64le_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_back
// Emits one character per cycle from the queue head unless the output stalls,
// keeps the line fill and line length register, drives the output register.
// ----------------------------------------------------------------------------
module b64le_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  head_valid,
	input  b64le_pkg::q_entry_t   head_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            char_code,
	output logic                  end_of_line,
	output logic                  end_of_message,
	output logic                  last_of_run
);
	import b64le_pkg::*;

	logic              phase_q;
	logic [LINE_W-1:0] line_fill_q;
	logic [LINE_W-1:0] line_len_q;
	logic              out_valid_q;
	logic [7:0]        char_q;
	logic              eol_q;
	logic              eom_q;
	logic              lor_q;

	logic [GROUP_W-1:0] cur_grp;
	logic               final_char;
	logic               msg_end;
	logic               load;
	logic [LINE_W-1:0]  fill_inc;
	logic               eol;

	// Select the character of the head entry and its flags.
	always_comb begin
		cur_grp    = phase_q ? head_entry.grp1 : head_entry.grp0;
		final_char = !head_entry.two_chars || phase_q;
		msg_end    = head_entry.msg_last && final_char;
		load       = head_valid && (!out_valid_q || out_ready);
		pop        = load && final_char;
		fill_inc   = line_fill_q + 1'b1;
		eol        = msg_end || (fill_inc >= line_len_q);
	end

	// Control state: phase within the entry, line fill, line length, valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			line_fill_q <= '0;
			line_len_q  <= LINE_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				line_len_q <= cfg_wr_data;
			end
			if (load) begin
				phase_q     <= !final_char;
				line_fill_q <= eol ? '0 : fill_inc;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= b64_char(cur_grp);
			eol_q  <= eol;
			eom_q  <= msg_end;
			lor_q  <= final_char;
		end
	end

	assign out_valid      = out_valid_q;
	assign char_code      = char_q;
	assign end_of_line    = eol_q;
	assign end_of_message = eom_q;
	assign last_of_run    = lor_q;

endmodule

FILE: hw/rtl/base64_line_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_encoder
// Base64 encoder without '=' padding that splits its characters into lines.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | data_byte, last_byte
//  output   | out_valid / out_ready| char_code, end_of_line, end_of_message,
//           |                      | last_of_run
//  config   | cfg_wr_en            | cfg_wr_data (line length)
//
// A byte is taken in any cycle the two-entry queue has room; the output port
// emits one character per cycle while out_ready is high, so a byte that
// yields two characters holds the output longer than a byte that yields one.
// A character passes through the queue and then the output register before it
// appears; the second character of a byte is sent from the same queue entry.
// Reset clears the held-over bits, the line fill and the queue, and sets the
// line length to 76. A stalled output lets the queue fill, then in_ready drops.
// ----------------------------------------------------------------------------
module base64_line_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_code,
	output logic       end_of_line,
	output logic       end_of_message,
	output logic       last_of_run
);
	import b64le_pkg::*;

	logic     q_full;
	logic     q_push;
	q_entry_t q_entry;
	logic     q_pop;
	logic     q_valid;
	q_entry_t q_head;

	// Front: classify bytes into character groups.
	b64le_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	// Queue between front and back.
	b64le_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_entry (q_head)
	);

	// Back: emit characters and track lines.
	b64le_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.head_valid     (q_valid),
		.head_entry     (q_head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.char_code      (char_code),
		.end_of_line    (end_of_line),
		.end_of_message (end_of_message),
		.last_of_run    (last_of_run)
	);

endmodule

FILE: hw/rtl/b64le_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_checker
// Port-level checks for the base64 line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64le_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_code,
	input logic       end_of_line,
	input logic       end_of_message,
	input logic       last_of_run
);

	// A stalled output transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code)
		&& $stable(end_of_line) && $stable(end_of_message) && $stable(last_of_run))
		else $error("output payload changed under stall");

	// The end of a message also ends the line and the byte's run.
	a_eom_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_message |-> end_of_line && last_of_run)
		else $error("end of message without end of line or run");

	// Every character is from the base64 alphabet.
	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code >= 8'd65 && char_code <= 8'd90)
		|| (char_code >= 8'd97 && char_code <= 8'd122)
		|| (char_code >= 8'd48 && char_code <= 8'd57)
		|| char_code == 8'd43 || char_code == 8'd47)
		else $error("character outside the alphabet");

	// The second character of a byte follows right after the first.
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("second character of a byte did not follow");

endmodule

bind base64_line_encoder b64le_checker u_b64le_checker (.*);
